@@ hw/rtl/ultrasonic_trimmed_mean_filter_defines.svh @@
// Assertion macros shared by the filter RTL.
`ifndef ULTRASONIC_TRIMMED_MEAN_FILTER_DEFINES_SVH
`define ULTRASONIC_TRIMMED_MEAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UTMF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/utmf_pkg.sv @@
`timescale 1ns / 1ps
package utmf_pkg;
	localparam int PULSE_W = 16;
	localparam int DIST_W = 20;
	localparam int WIN_DEPTH = 6;
	localparam int FILL_W = 3;
	localparam int FRACTION_BITS_DEF = 4;
	localparam int RECIP_W = 30;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 2;

	localparam logic [MODE_W-1:0] MODE_RAW = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MM = 2'd2;
	localparam logic [MODE_W-1:0] MODE_IN = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_UNIT_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 1'd1;

	// Reciprocals round(2^32 / divisor).
	localparam logic [RECIP_W-1:0] RECIP_CM = 30'd73796689;
	localparam logic [RECIP_W-1:0] RECIP_MM = 30'd737966889;
	localparam logic [RECIP_W-1:0] RECIP_IN = 30'd29020049;
	localparam logic [32:0] ROUND_HALF = 33'h0_8000_0000;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef logic [DIST_W-1:0] dist_t;
	typedef logic [WIN_DEPTH-1:0][DIST_W-1:0] win_t;

	function automatic logic [RECIP_W-1:0] recip_for_mode(input logic [MODE_W-1:0] mode);
		logic [RECIP_W-1:0] r;
		unique case (mode)
			MODE_CM: r = RECIP_CM;
			MODE_MM: r = RECIP_MM;
			MODE_IN: r = RECIP_IN;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

@@ hw/rtl/utmf_conv.sv @@
`timescale 1ns / 1ps
module utmf_conv #(
	parameter int FRACTION_BITS = utmf_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [utmf_pkg::PULSE_W-1:0]  pulse,
	input  logic [utmf_pkg::MODE_W-1:0]   mode,
	output utmf_pkg::dist_t               q
);
	import utmf_pkg::*;

	localparam int SC_W = PULSE_W + FRACTION_BITS;
	localparam int PROD_W = SC_W + RECIP_W;
	localparam int EXT_W = (SC_W > DIST_W) ? SC_W : DIST_W;

	logic [SC_W-1:0]   scaled;
	logic [SC_W-1:0]   scaled_s1;
	logic [PROD_W-1:0] prod_s1;
	logic              raw_s1;
	logic [PROD_W:0]   rounded;
	logic [EXT_W-1:0]  pre;

	assign scaled = SC_W'(pulse) << FRACTION_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			scaled_s1 <= scaled;
			prod_s1 <= PROD_W'(scaled) * PROD_W'(recip_for_mode(mode));
			raw_s1 <= (mode == MODE_RAW);
		end
	end

	always_comb begin
		rounded = {1'b0, prod_s1} + (PROD_W + 1)'(ROUND_HALF);
		if (raw_s1) begin
			pre = EXT_W'(scaled_s1);
		end else begin
			pre = EXT_W'(rounded[PROD_W:32]);
		end
		q = (pre > EXT_W'(DIST_MAX)) ? DIST_MAX : pre[DIST_W-1:0];
	end
endmodule

@@ hw/rtl/utmf_cell.sv @@
`timescale 1ns / 1ps
module utmf_cell (
	input  logic            clk,
	input  logic            shift_en,
	input  utmf_pkg::dist_t d,
	output utmf_pkg::dist_t q
);
	import utmf_pkg::*;

	dist_t sample_q;

	// One window slot; takes its neighbor's sample on every shift.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;
endmodule

@@ hw/rtl/utmf_trim.sv @@
`timescale 1ns / 1ps
module utmf_trim (
	input  logic            clk,
	input  logic            en,
	input  utmf_pkg::win_t  win,
	output utmf_pkg::dist_t mean
);
	import utmf_pkg::*;

	localparam int PAIRS = WIN_DEPTH / 2;
	localparam int PSUM_W = DIST_W + 1;
	localparam int SUM_W = DIST_W + 3;

	logic [PAIRS-1:0][PSUM_W-1:0] psum_s3;
	logic [PAIRS-1:0][DIST_W-1:0] pmin_s3;
	logic [PAIRS-1:0][DIST_W-1:0] pmax_s3;
	logic [SUM_W-1:0]             total;
	dist_t                        lo;
	dist_t                        hi;
	logic [SUM_W-1:0]             mid;

	// First level of the tree: one adder and one compare per pair of slots.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < PAIRS; p++) begin
				psum_s3[p] <= PSUM_W'(win[2*p]) + PSUM_W'(win[2*p+1]);
				if (win[2*p] < win[2*p+1]) begin
					pmin_s3[p] <= win[2*p];
					pmax_s3[p] <= win[2*p+1];
				end else begin
					pmin_s3[p] <= win[2*p+1];
					pmax_s3[p] <= win[2*p];
				end
			end
		end
	end

	always_comb begin
		total = '0;
		lo = pmin_s3[0];
		hi = pmax_s3[0];
		for (int p = 0; p < PAIRS; p++) begin
			total = total + SUM_W'(psum_s3[p]);
			if (pmin_s3[p] < lo) lo = pmin_s3[p];
			if (pmax_s3[p] > hi) hi = pmax_s3[p];
		end
		mid = total - SUM_W'(lo) - SUM_W'(hi);
		mean = mid[DIST_W+1:2];
	end
endmodule

@@ hw/rtl/ultrasonic_trimmed_mean_filter.sv @@
`timescale 1ns / 1ps
// Channel | Handshake              | Payload
// in      | in_valid / in_stall    | pulse_us
// out     | out_valid / out_stall  | distance_q4, filtered
// cfg     | cfg_wr_en              | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each item passes, from acceptance to a valid result,
// through multiply, round and window shift, pair compare and final trim.
// The whole pipeline advances together; in_stall is high only while a result waits
// in the output register under out_stall.
// Reset clears the valid bits, the configuration and the window fill count.
`include "ultrasonic_trimmed_mean_filter_defines.svh"
module ultrasonic_trimmed_mean_filter #(
	parameter int FRACTION_BITS = utmf_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [utmf_pkg::PULSE_W-1:0]    pulse_us,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [utmf_pkg::DIST_W-1:0]     distance_q4,
	output logic                            filtered,
	input  logic                            cfg_wr_en,
	input  logic [utmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [utmf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import utmf_pkg::*;

	logic              adv;
	logic              v_s1;
	logic              v_s2;
	logic              v_s3;
	logic              out_valid_q;
	logic [MODE_W-1:0] unit_mode_q;
	logic              filter_enable_q;
	logic [FILL_W-1:0] fill_q;
	logic              win_shift;
	dist_t             conv_q;
	dist_t             q_s2;
	dist_t             q_s3;
	logic              filt_s2;
	logic              filt_s3;
	dist_t             mean;
	win_t              win;
	dist_t             distance_q;
	logic              filtered_q;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign win_shift = adv && v_s1 && filter_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_mode_q <= MODE_RAW;
			filter_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_UNIT_MODE: unit_mode_q <= cfg_data[MODE_W-1:0];
				REG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
			fill_q <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
			if (win_shift && fill_q != FILL_W'(WIN_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	utmf_conv #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_conv (
		.clk  (clk),
		.en   (adv),
		.pulse(pulse_us),
		.mode (unit_mode_q),
		.q    (conv_q)
	);

	// Newest sample enters the last cell; the oldest falls out of cell zero.
	// Slot order does not matter to the trimmed mean once all six are filled.
	for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
		if (i == WIN_DEPTH - 1) begin : g_tail
			utmf_cell u_cell (
				.clk     (clk),
				.shift_en(win_shift),
				.d       (conv_q),
				.q       (win[i])
			);
		end else begin : g_body
			utmf_cell u_cell (
				.clk     (clk),
				.shift_en(win_shift),
				.d       (win[i+1]),
				.q       (win[i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s2 <= conv_q;
			filt_s2 <= filter_enable_q && (fill_q >= FILL_W'(WIN_DEPTH - 1));
			q_s3 <= q_s2;
			filt_s3 <= filt_s2;
			distance_q <= filt_s3 ? mean : q_s3;
			filtered_q <= filt_s3;
		end
	end

	utmf_trim u_trim (
		.clk (clk),
		.en  (adv),
		.win (win),
		.mean(mean)
	);

	assign out_valid = out_valid_q;
	assign distance_q4 = distance_q;
	assign filtered = filtered_q;

	`UTMF_ASSERT_IMP(a_fill_bound, clk, arst_n, 1'b1, fill_q <= FILL_W'(WIN_DEPTH), "fill count above window depth")
	`UTMF_ASSERT_IMP(a_fill_needs_filter, clk, arst_n, !$stable(fill_q), filter_enable_q, "window filled while filter off")
	`UTMF_ASSERT_NEXT(a_filt_flag, clk, arst_n, adv && v_s1 && filter_enable_q && fill_q >= FILL_W'(WIN_DEPTH - 1), v_s2 && filt_s2, "full window item not marked filtered")
	`UTMF_ASSERT_IMP(a_filtered_src, clk, arst_n, out_valid_q && filtered_q, filter_enable_q, "filtered result with filter off")
endmodule
